/* src/mic_pkg.sv */
package mic_pkg;

    localparam int RAW_W     = 20;
    localparam int D_W       = 21;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = D_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CAL_W     = 22;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int CFG_IDX_W = 3;
    localparam int AXES      = 3;

    localparam int CAL_MAX = (1 << (CAL_W - 1)) - 1;
    localparam int CAL_MIN = -(1 << (CAL_W - 1));

    typedef logic signed [RAW_W-1:0]  raw_t;
    typedef logic signed [D_W-1:0]    diff_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [CAL_W-1:0]  cal_t;
    typedef logic [ROW_W-1:0]         row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X     = 3'd0,
        REG_OFFSET_Y     = 3'd1,
        REG_OFFSET_Z     = 3'd2,
        REG_MATRIX_ROW_0 = 3'd3,
        REG_MATRIX_ROW_1 = 3'd4,
        REG_MATRIX_ROW_2 = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        raw_t offset_x;
        raw_t offset_y;
        raw_t offset_z;
        row_t matrix_row_0;
        row_t matrix_row_1;
        row_t matrix_row_2;
    } cal_cfg_t;

    // -3.98, -5.29, 27.28 uT at 0.00625 uT per count
    localparam raw_t OFFSET_X_RST = 20'hFFD83;
    localparam raw_t OFFSET_Y_RST = 20'hFFCB2;
    localparam raw_t OFFSET_Z_RST = 20'h0110D;
    // Q2.14 diagonal 1.018, 0.978, 1.006 with symmetric off-diagonal terms
    localparam row_t ROW_0_RST = 48'd2117405983015;
    localparam row_t ROW_1_RST = 48'd563690929979;
    localparam row_t ROW_2_RST = 48'd70789659558380;

endpackage

/* src/mic_if.sv */
interface mic_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] x_high;
    logic [7:0] x_mid;
    logic [7:0] y_high;
    logic [7:0] y_mid;
    logic [7:0] z_high;
    logic [7:0] z_mid;
    logic [7:0] x_low_byte;
    logic [7:0] y_low_byte;
    logic [7:0] z_low_byte;

    modport source (
        output valid, x_high, x_mid, y_high, y_mid, z_high, z_mid,
               x_low_byte, y_low_byte, z_low_byte,
        input  ready
    );
    modport sink (
        input  valid, x_high, x_mid, y_high, y_mid, z_high, z_mid,
               x_low_byte, y_low_byte, z_low_byte,
        output ready
    );
endinterface

interface mic_result_if;
    logic          valid;
    logic          ready;
    mic_pkg::raw_t raw_x;
    mic_pkg::raw_t raw_y;
    mic_pkg::raw_t raw_z;
    mic_pkg::cal_t cal_x;
    mic_pkg::cal_t cal_y;
    mic_pkg::cal_t cal_z;
    logic          saturated;

    modport source (
        output valid, raw_x, raw_y, raw_z, cal_x, cal_y, cal_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, raw_x, raw_y, raw_z, cal_x, cal_y, cal_z, saturated,
        output ready
    );
endinterface

/* src/mic_cfg_regs.sv */
module mic_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [mic_pkg::CFG_IDX_W-1:0]     index,
    input  logic [mic_pkg::ROW_W-1:0]         data,
    output mic_pkg::cal_cfg_t                 cfg
);
    import mic_pkg::*;

    cal_cfg_t cfg_reg;
    cal_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_OFFSET_X:     cfg_next.offset_x     = data[RAW_W-1:0];
                REG_OFFSET_Y:     cfg_next.offset_y     = data[RAW_W-1:0];
                REG_OFFSET_Z:     cfg_next.offset_z     = data[RAW_W-1:0];
                REG_MATRIX_ROW_0: cfg_next.matrix_row_0 = data;
                REG_MATRIX_ROW_1: cfg_next.matrix_row_1 = data;
                REG_MATRIX_ROW_2: cfg_next.matrix_row_2 = data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x     <= OFFSET_X_RST;
            cfg_reg.offset_y     <= OFFSET_Y_RST;
            cfg_reg.offset_z     <= OFFSET_Z_RST;
            cfg_reg.matrix_row_0 <= ROW_0_RST;
            cfg_reg.matrix_row_1 <= ROW_1_RST;
            cfg_reg.matrix_row_2 <= ROW_2_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    a_reset_values: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (cfg_reg.offset_x == OFFSET_X_RST &&
                          cfg_reg.offset_z == OFFSET_Z_RST &&
                          cfg_reg.matrix_row_2 == ROW_2_RST))
        else $error("config registers not at reset values after reset");

endmodule

/* src/mic_front.sv */
module mic_front (
    input  logic                clk,
    input  logic                rst_n,
    mic_sample_if.sink          sample,
    input  mic_pkg::cal_cfg_t   cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output mic_pkg::raw_t       raw [mic_pkg::AXES],
    output mic_pkg::diff_t      diff [mic_pkg::AXES]
);
    import mic_pkg::*;

    logic  valid_reg;
    raw_t  raw_reg  [AXES];
    diff_t diff_reg [AXES];
    raw_t  raw_next [AXES];
    raw_t  offs     [AXES];
    diff_t diff_next [AXES];
    logic  take;

    assign sample.ready = !valid_reg || out_ready;
    assign take = sample.valid && sample.ready;

    // subtracting midscale 2^19 from a 20-bit value flips the top bit
    assign raw_next[0] = {~sample.x_high[7], sample.x_high[6:0], sample.x_mid,
                          sample.x_low_byte[7:4]};
    assign raw_next[1] = {~sample.y_high[7], sample.y_high[6:0], sample.y_mid,
                          sample.y_low_byte[7:4]};
    assign raw_next[2] = {~sample.z_high[7], sample.z_high[6:0], sample.z_mid,
                          sample.z_low_byte[7:4]};

    assign offs[0] = cfg.offset_x;
    assign offs[1] = cfg.offset_y;
    assign offs[2] = cfg.offset_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            diff_next[a] = diff_t'(raw_next[a]) - diff_t'(offs[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            raw_reg  <= raw_next;
            diff_reg <= diff_next;
        end
    end

    assign out_valid = valid_reg;
    assign raw  = raw_reg;
    assign diff = diff_reg;

endmodule

/* src/mic_matmul.sv */
module mic_matmul (
    input  logic                clk,
    input  logic                rst_n,
    input  mic_pkg::cal_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  mic_pkg::raw_t       in_raw  [mic_pkg::AXES],
    input  mic_pkg::diff_t      in_diff [mic_pkg::AXES],
    output logic                out_valid,
    input  logic                out_ready,
    output mic_pkg::raw_t       out_raw [mic_pkg::AXES],
    output mic_pkg::acc_t       out_acc [mic_pkg::AXES]
);
    import mic_pkg::*;

    localparam int NPROD = AXES * AXES;

    row_t  rows [AXES];
    coef_t coef [NPROD];
    prod_t prod_next [NPROD];

    // product stage
    logic  p_valid_reg;
    logic  p_ready;
    prod_t prod_reg [NPROD];
    raw_t  p_raw_reg [AXES];

    // row sum stage
    logic  a_valid_reg;
    logic  a_ready;
    acc_t  acc_reg  [AXES];
    acc_t  acc_next [AXES];
    raw_t  a_raw_reg [AXES];

    assign rows[0] = cfg.matrix_row_0;
    assign rows[1] = cfg.matrix_row_1;
    assign rows[2] = cfg.matrix_row_2;

    assign a_ready  = !a_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || a_ready;
    assign in_ready = p_ready;

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                coef[r*AXES + c] = rows[r][c*COEF_W +: COEF_W];
                prod_next[r*AXES + c] = coef[r*AXES + c] * in_diff[c];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            acc_next[r] = acc_t'(prod_reg[r*AXES]) + acc_t'(prod_reg[r*AXES + 1])
                        + acc_t'(prod_reg[r*AXES + 2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (a_ready)
            begin
                a_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && p_ready)
        begin
            prod_reg  <= prod_next;
            p_raw_reg <= in_raw;
        end
        if (p_valid_reg && a_ready)
        begin
            acc_reg   <= acc_next;
            a_raw_reg <= p_raw_reg;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_raw   = a_raw_reg;
    assign out_acc   = acc_reg;

endmodule

/* src/mic_sat.sv */
module mic_sat #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mic_pkg::raw_t       in_raw [mic_pkg::AXES],
    input  mic_pkg::acc_t       in_acc [mic_pkg::AXES],
    mic_result_if.source        result
);
    import mic_pkg::*;

    localparam acc_t BIAS    = acc_t'((1 << COEF_FRAC_BITS) - 1);
    localparam acc_t SAT_MAX = acc_t'(CAL_MAX);
    localparam acc_t SAT_MIN = acc_t'(CAL_MIN);

    logic valid_reg;
    raw_t raw_reg [AXES];
    cal_t cal_reg [AXES];
    cal_t cal_next [AXES];
    logic sat_reg;
    logic sat_next;
    acc_t biased [AXES];
    acc_t quot [AXES];

    assign in_ready = !valid_reg || result.ready;

    // truncation toward zero: bias negative sums before the arithmetic shift
    always_comb
    begin
        sat_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            biased[a] = in_acc[a] + (in_acc[a][ACC_W-1] ? BIAS : '0);
            quot[a]   = biased[a] >>> COEF_FRAC_BITS;
            if (quot[a] > SAT_MAX)
            begin
                cal_next[a] = cal_t'(SAT_MAX);
                sat_next    = 1'b1;
            end
            else if (quot[a] < SAT_MIN)
            begin
                cal_next[a] = cal_t'(SAT_MIN);
                sat_next    = 1'b1;
            end
            else
            begin
                cal_next[a] = quot[a][CAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg <= in_raw;
            cal_reg <= cal_next;
            sat_reg <= sat_next;
        end
    end

    assign result.valid     = valid_reg;
    assign result.raw_x     = raw_reg[0];
    assign result.raw_y     = raw_reg[1];
    assign result.raw_z     = raw_reg[2];
    assign result.cal_x     = cal_reg[0];
    assign result.cal_y     = cal_reg[1];
    assign result.cal_z     = cal_reg[2];
    assign result.saturated = sat_reg;

    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && sat_reg) |->
            (cal_reg[0] == cal_t'(SAT_MAX) || cal_reg[0] == cal_t'(SAT_MIN) ||
             cal_reg[1] == cal_t'(SAT_MAX) || cal_reg[1] == cal_t'(SAT_MIN) ||
             cal_reg[2] == cal_t'(SAT_MAX) || cal_reg[2] == cal_t'(SAT_MIN)))
        else $error("saturated flag set with no axis on a rail");

    a_rail_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && quot[0] > SAT_MAX) |=> (valid_reg && sat_reg))
        else $error("x overflow not flagged");

endmodule

/* src/magnetometer_iron_calibration_unit.sv */
// Hard- and soft-iron calibration for a three-axis magnetometer frame. Each
// accepted word is a nine-byte frame; the result word carries the signed raw
// counts and the calibrated counts M * (raw - offset) / 2^COEF_FRAC_BITS,
// truncated toward zero and clipped to 22 bits, with a flag when any axis
// clipped. The pipeline has four register stages (unpack and offset, nine
// 16x21 products, row sums, scale and clip in the output register), and a
// new frame can be taken every cycle while the output is not stalled.
// Back-pressure travels back through the stages, so a stalled output holds
// its word while the earlier stages keep filling. The user must write
// offsets and matrix rows through the cfg port only while no frame is in
// flight; the block does not enforce this. They reset to the factory
// calibration.
module magnetometer_iron_calibration_unit #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mic_sample_if.sink                     sample,
    mic_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [mic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mic_pkg::ROW_W-1:0]      cfg_data
);
    import mic_pkg::*;

    cal_cfg_t cfg;

    logic  f_valid;
    logic  f_ready;
    raw_t  f_raw  [AXES];
    diff_t f_diff [AXES];

    logic  m_valid;
    logic  m_ready;
    raw_t  m_raw [AXES];
    acc_t  m_acc [AXES];

    mic_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    mic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cfg       (cfg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .raw       (f_raw),
        .diff      (f_diff)
    );

    mic_matmul u_matmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_raw    (f_raw),
        .in_diff   (f_diff),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_raw   (m_raw),
        .out_acc   (m_acc)
    );

    mic_sat #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m_valid),
        .in_ready (m_ready),
        .in_raw   (m_raw),
        .in_acc   (m_acc),
        .result   (result)
    );

    // input only stalls once every stage is full behind a blocked output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a blocked output word");

endmodule
